@@ design/bmd_pkg.sv @@
// Shared types, constants and helpers for the Bayer demosaicer.
package bmd_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int SLOT_COUNT    = 8;
  localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
  localparam int WIN           = 5;

  localparam logic [10:0] WIDTH_RESET  = 11'd390;
  localparam logic [11:0] HEIGHT_RESET = 12'd300;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [WIN-1:0][WIN-1:0][7:0] window_t;

  typedef struct packed {
    logic row_odd;
    logic col_odd;
  } pix_ctl_t;

  function automatic logic [7:0] finish(input logic signed [13:0] s);
    logic [9:0] q;
    q = s[13:4];
    if (s <= 14'sd0) begin
      return 8'd0;
    end
    if (q > 10'd255) begin
      return 8'hFF;
    end
    return q[7:0];
  endfunction

endpackage

@@ design/bmd_colmem.sv @@
// Column memory: one word per column holding all row slots, byte write, forwarded read.
module bmd_colmem import bmd_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  slot_t                               wslot,
  input  logic [7:0]                          wdata,
  input  logic                                re,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [SLOT_COUNT-1:0][7:0]          rdata
);

  logic [SLOT_COUNT-1:0][7:0] mem [DEPTH];
  logic [SLOT_COUNT-1:0][7:0] word_q;
  logic                       hit;
  slot_t                      fslot;
  logic [7:0]                 fdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wslot] <= wdata;
    end
    if (re) begin
      word_q <= mem[raddr];
      hit    <= we && (waddr == raddr);
      fslot  <= wslot;
      fdata  <= wdata;
    end
  end

  always_comb begin
    rdata = word_q;
    if (hit) begin
      rdata[fslot] = fdata;
    end
  end

endmodule

@@ design/bmd_kernel.sv @@
// Malvar-He-Cutler 5x5 kernels and color selection by mosaic phase.
module bmd_kernel import bmd_pkg::*; (
  input  window_t    win,
  input  pix_ctl_t   ctl,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic signed [13:0] c, h1, h2, v1, v2, d;
  logic signed [13:0] cross_sum, horiz, vert, diag;

  always_comb begin
    c  = 14'(win[2][2]);
    h1 = 14'(win[2][1]) + 14'(win[2][3]);
    h2 = 14'(win[2][0]) + 14'(win[2][4]);
    v1 = 14'(win[1][2]) + 14'(win[3][2]);
    v2 = 14'(win[0][2]) + 14'(win[4][2]);
    d  = 14'(win[1][1]) + 14'(win[1][3]) + 14'(win[3][1]) + 14'(win[3][3]);
    cross_sum = 14'sd8 * c + 14'sd4 * (h1 + v1) - 14'sd2 * (h2 + v2);
    horiz = 14'sd10 * c + 14'sd8 * h1 - 14'sd2 * h2 - 14'sd2 * d + v2;
    vert  = 14'sd10 * c + 14'sd8 * v1 - 14'sd2 * v2 - 14'sd2 * d + h2;
    diag  = 14'sd12 * c + 14'sd4 * d - 14'sd3 * (h2 + v2);
    case ({ctl.row_odd, ctl.col_odd})
      2'b00: begin
        red = finish(horiz); green = win[2][2]; blue = finish(vert);
      end
      2'b01: begin
        red = win[2][2]; green = finish(cross_sum); blue = finish(diag);
      end
      2'b10: begin
        red = finish(diag); green = finish(cross_sum); blue = win[2][2];
      end
      default: begin
        red = finish(vert); green = win[2][2]; blue = finish(horiz);
      end
    endcase
  end

endmodule

@@ design/bayer_mhc_demosaic.sv @@
// Bayer GRBG demosaicer, 5x5 Malvar-He-Cutler kernels, mirrored borders.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata = sample, tuser = action
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata = red,green,blue; tlast = row_end;
//                                                tuser = frame_end
//  cfg       in   cfg_we                         cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a result leaves through the column memory
// read, the window register and the kernel output register after the item that completes its window.
// Five column memories, written in parallel, each give one window column per cycle unless the pipeline is stalled.
// Reset is synchronous; the memories are not cleared.
// A stalled output fills the pipeline bubbles first, then holds s_axis_tready low.
module bayer_mhc_demosaic import bmd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sample
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] frame_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int MW = AW + 3;

  logic [10:0]   frame_width;
  logic [11:0]   frame_height;
  logic [11:0]   in_row, out_row;
  logic [AW-1:0] in_col, out_col;
  logic [CW-1:0] w_eff;
  logic [11:0]   h_eff;

  logic          v0, v1, ov;
  logic          s0_rdy, s1_rdy, s2_rdy;
  logic          accept, take_sample, ready_cond, emit;

  logic [11:0]   in_row_next, out_row_next;
  logic [AW-1:0] in_col_next, out_col_next;
  logic [CW-1:0] in_col_inc, out_col_inc, cc;
  logic [12:0]   rr_full;
  logic [11:0]   rr;
  logic [CW:0]   cc_full;

  slot_t         rslot_c [WIN];
  logic [AW-1:0] rcol_c  [WIN];
  slot_t         rslot   [WIN];
  pix_ctl_t      ctl0, ctl1;
  logic          row_end0, frame_end0, row_end1, frame_end1;

  logic [SLOT_COUNT-1:0][7:0] colword [WIN];
  window_t       win_c, window_regs;
  logic [7:0]    red, green, blue;

  logic signed [13:0]   ri, hm1;
  logic signed [MW-1:0] ci, wm1;

  always_comb begin
    if (frame_width < 11'd3) begin
      w_eff = CW'(3);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    h_eff = (frame_height < 12'd3) ? 12'd3 : frame_height;
  end

  assign s2_rdy        = !ov || m_axis_tready;
  assign s1_rdy        = !v1 || s2_rdy;
  assign s0_rdy        = !v0 || s1_rdy;
  assign s_axis_tready = s0_rdy;
  assign accept        = s_axis_tvalid && s0_rdy;
  assign take_sample   = accept && (s_axis_tuser == ACT_SAMPLE) && (in_row < h_eff);

  always_comb begin
    in_col_inc  = {1'b0, in_col} + CW'(1);
    in_col_next = in_col;
    in_row_next = in_row;
    if (take_sample) begin
      if (in_col_inc >= w_eff) begin
        in_col_next = '0;
        in_row_next = in_row + 12'd1;
      end else begin
        in_col_next = in_col_inc[AW-1:0];
      end
    end
    rr_full = {1'b0, out_row} + 13'd2;
    rr      = (rr_full > {1'b0, h_eff - 12'd1}) ? (h_eff - 12'd1) : rr_full[11:0];
    cc_full = {2'b0, out_col} + (CW+1)'(2);
    cc      = (cc_full > {1'b0, w_eff - CW'(1)}) ? (w_eff - CW'(1)) : cc_full[CW-1:0];
    ready_cond = (rr < in_row_next) ||
                 ((rr == in_row_next) && (cc < {1'b0, in_col_next}));
    emit = accept && ready_cond;
  end

  always_comb begin
    out_col_inc = {1'b0, out_col} + CW'(1);
    hm1 = $signed({2'b00, h_eff}) - 14'sd1;
    wm1 = $signed({2'b00, w_eff}) - MW'(1);
    ri  = '0;
    ci  = '0;
    for (int k = 0; k < WIN; k++) begin
      ri = $signed({2'b00, out_row}) + 14'(k) - 14'sd2;
      if (ri < 0) begin
        ri = -ri;
      end else if (ri > hm1) begin
        ri = 14'sd2 * hm1 - ri;
      end
      rslot_c[k] = ri[SLOT_BITS-1:0];
      ci = $signed({3'b000, out_col}) + MW'(k) - MW'(2);
      if (ci < 0) begin
        ci = -ci;
      end else if (ci > wm1) begin
        ci = MW'(2) * wm1 - ci;
      end
      rcol_c[k] = ci[AW-1:0];
    end
  end

  always_comb begin
    out_row_next = out_row;
    out_col_next = out_col;
    if (emit) begin
      if (out_col_inc >= w_eff) begin
        out_col_next = '0;
        out_row_next = out_row + 12'd1;
      end else begin
        out_col_next = out_col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          frame_height <= cfg_data;
      endcase
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (emit && (out_row_next >= h_eff)) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  for (genvar b = 0; b < WIN; b++) begin : g_bank
    bmd_colmem #(.DEPTH(MAX_WIDTH)) u_mem (
      .clk   (clk),
      .we    (take_sample),
      .waddr (in_col),
      .wslot (in_row[SLOT_BITS-1:0]),
      .wdata (s_axis_tdata),
      .re    (s0_rdy),
      .raddr (rcol_c[b]),
      .rdata (colword[b])
    );
  end

  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      for (int k = 0; k < WIN; k++) begin
        rslot[k] <= rslot_c[k];
      end
      ctl0.row_odd <= out_row[0];
      ctl0.col_odd <= out_col[0];
      row_end0     <= ({1'b0, out_col} == w_eff - CW'(1));
      frame_end0   <= ({1'b0, out_col} == w_eff - CW'(1)) && (out_row == h_eff - 12'd1);
    end
  end

  always_comb begin
    for (int y = 0; y < WIN; y++) begin
      for (int x = 0; x < WIN; x++) begin
        win_c[y][x] = colword[x][rslot[y]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      window_regs <= win_c;
      ctl1        <= ctl0;
      row_end1    <= row_end0;
      frame_end1  <= frame_end0;
    end
  end

  bmd_kernel u_kernel (
    .win   (window_regs),
    .ctl   (ctl1),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      m_axis_tdata <= {blue, green, red};
      m_axis_tlast <= row_end1;
      m_axis_tuser <= frame_end1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (s0_rdy) v0 <= emit;
      if (s1_rdy) v1 <= v0;
      if (s2_rdy) ov <= v1;
    end
  end

  assign m_axis_tvalid = ov;

  a_out_row_range: assert property (@(posedge clk) disable iff (rst)
    out_row < h_eff) else $error("output row beyond frame height");

  a_in_row_range: assert property (@(posedge clk) disable iff (rst)
    in_row <= h_eff) else $error("input row beyond frame height");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_col} < w_eff) else $error("output column beyond frame width");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("frame end without row end");

  a_emit_fills_pipe: assert property (@(posedge clk) disable iff (rst)
    emit |=> v0) else $error("emitted pixel lost at read stage");

endmodule

@@ tb/sv/tb_bayer_mhc_demosaic.sv @@
// Self-checking testbench for the bayer_mhc_demosaic GRBG demosaicer.
`timescale 1ns / 1ps

module tb_bayer_mhc_demosaic;
  import bmd_pkg::*;

  localparam int STORE_W     = 1024;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic       act;
    logic [7:0] smp;
  } bayer_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } rgb_pixel_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_data;

  bayer_item_t raw_items[$];
  rgb_pixel_t  pixels_due[$];

  logic [7:0]  row_mem [SLOT_COUNT][STORE_W];
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  int          rx_row, rx_col, tx_row, tx_col;

  int  error_count;
  int  quiet_cycles;
  bit  in_taken;
  int  burst_left, gap_left, gap_max;
  int  stall_mode, stall_left;
  bayer_item_t drive_item;

  bayer_mhc_demosaic DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int used_width();
    int w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > STORE_W) w = STORE_W;
    return w;
  endfunction

  function automatic int used_height();
    int h;
    h = height_reg;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic int reflect(input int i, input int n);
    int k;
    k = (i < 0) ? -i : i;
    if (k > n - 1) k = 2 * (n - 1) - k;
    if (k < 0) k = 0;
    if (k > n - 1) k = n - 1;
    return k;
  endfunction

  function automatic logic [7:0] scale_clamp(input int s);
    int q;
    if (s <= 0) return 8'd0;
    q = s / 16;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Advance the frame position model by one transfer; true when a pixel leaves.
  function automatic bit demosaic_step(input bayer_item_t it, output rgb_pixel_t px);
    int w, h, rr, cc, c, h1, h2, v1, v2, d;
    int cross_sum, horiz, vert, diag;
    int win [5][5];
    w = used_width();
    h = used_height();
    if (it.act == ACT_SAMPLE && rx_row < h) begin
      row_mem[rx_row % SLOT_COUNT][rx_col] = it.smp;
      rx_col++;
      if (rx_col >= w) begin
        rx_col = 0;
        rx_row++;
      end
    end
    rr = (tx_row + 2 > h - 1) ? h - 1 : tx_row + 2;
    cc = (tx_col + 2 > w - 1) ? w - 1 : tx_col + 2;
    if (rr * w + cc >= rx_row * w + rx_col) return 1'b0;
    for (int dy = 0; dy < 5; dy++)
      for (int dx = 0; dx < 5; dx++)
        win[dy][dx] = row_mem[reflect(tx_row + dy - 2, h) % SLOT_COUNT]
                             [reflect(tx_col + dx - 2, w)];
    c  = win[2][2];
    h1 = win[2][1] + win[2][3];
    h2 = win[2][0] + win[2][4];
    v1 = win[1][2] + win[3][2];
    v2 = win[0][2] + win[4][2];
    d  = win[1][1] + win[1][3] + win[3][1] + win[3][3];
    cross_sum = 8 * c + 4 * (h1 + v1) - 2 * (h2 + v2);
    horiz = 10 * c + 8 * h1 - 2 * h2 - 2 * d + v2;
    vert  = 10 * c + 8 * v1 - 2 * v2 - 2 * d + h2;
    diag  = 12 * c + 4 * d - 3 * (h2 + v2);
    case ({tx_row[0], tx_col[0]})
      2'b00: begin
        px.red = scale_clamp(horiz); px.green = c[7:0]; px.blue = scale_clamp(vert);
      end
      2'b01: begin
        px.red = c[7:0]; px.green = scale_clamp(cross_sum); px.blue = scale_clamp(diag);
      end
      2'b10: begin
        px.red = scale_clamp(diag); px.green = scale_clamp(cross_sum); px.blue = c[7:0];
      end
      default: begin
        px.red = scale_clamp(vert); px.green = c[7:0]; px.blue = scale_clamp(horiz);
      end
    endcase
    px.row_end   = (tx_col == w - 1);
    px.frame_end = (tx_col == w - 1) && (tx_row == h - 1);
    tx_col++;
    if (tx_col >= w) begin
      tx_col = 0;
      tx_row++;
      if (tx_row >= h) begin
        rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rgb_pixel_t px;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data[10:0];
        else height_reg = cfg_data;
        rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        if (demosaic_step(drive_item, px)) pixels_due.push_back(px);
      end
    end
  end

  always @(posedge clk) begin
    rgb_pixel_t exp_px;
    logic [25:0] got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $realtime, got);
        error_count++;
      end else begin
        exp_px = pixels_due.pop_front();
        want = {exp_px.frame_end, exp_px.row_end, exp_px.blue, exp_px.green, exp_px.red};
        if (got !== want) begin
          $display("%0t: pixel mismatch, expected %h, actual %h", $realtime, want, got);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (raw_items.size() > 0) begin
          drive_item = raw_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drive_item.smp;
          s_axis_tuser  <= drive_item.act;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bayer_mhc_demosaic regression: fail");
      $finish;
    end
  end

  task automatic push_item(input logic act, input logic [7:0] smp);
    bayer_item_t it;
    it.act = act;
    it.smp = smp;
    raw_items.push_back(it);
  endtask

  task automatic settle();
    while (raw_items.size() > 0 || s_axis_tvalid || pixels_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= 12'($urandom);
  endtask

  // Queue one whole frame followed by a flush; the flush may carry stray samples.
  task automatic queue_frame(input int w, input int h, input int fill, input bit force_stray);
    logic [7:0] v;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (r < h - 2 && $urandom_range(0, 7) == 0) push_item(ACT_DRAIN, 8'($urandom));
        case (fill)
          0: v = 8'($urandom);
          1: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          2: v = ((r + c) % 2 == 0) ? 8'hFF : 8'h00;
          default: v = (r[0] ^ c[0]) ? 8'h00 : 8'hFF;
        endcase
        push_item(ACT_SAMPLE, v);
      end
    if (force_stray) push_item(ACT_SAMPLE, 8'hA5);
    for (int i = 0; i < w; i++)
      push_item($urandom_range(0, 2) == 0 ? ACT_SAMPLE : ACT_DRAIN, 8'($urandom));
    for (int i = 0; i < 2 * w + 10; i++) push_item(ACT_DRAIN, 8'($urandom));
  endtask

  initial begin
    int w, h, wv, hv, sent;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_DRAIN;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    error_count = 0;
    quiet_cycles = 0;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    gap_max = 0;
    stall_mode = 0;
    stall_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    push_item(ACT_DRAIN, 8'hFF);
    push_item(ACT_DRAIN, 8'h00);
    queue_frame(3, 3, 2, 1'b1);
    settle();

    write_reg(REG_FRAME_WIDTH, 12'd1);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    queue_frame(3, 3, 3, 1'b1);
    settle();

    gap_max = 6;
    stall_mode = 2;
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd4095);
    for (int i = 0; i < 36; i++) push_item(ACT_SAMPLE, 8'($urandom));
    for (int i = 0; i < 10; i++) push_item(ACT_DRAIN, 8'($urandom));
    settle();

    gap_max = 0;
    stall_mode = 0;
    write_reg(REG_FRAME_HEIGHT, 12'd3);

    sent = 0;
    w = 3;
    h = 3;
    while (sent < 1100) begin
      gap_max = $urandom_range(0, 2) * 4;
      stall_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) begin
        wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
        hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        wv = wv | ($urandom_range(0, 1) << 11);
        write_reg(REG_FRAME_WIDTH, wv[11:0]);
        if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, hv[11:0]);
        w = used_width();
        h = used_height();
      end
      queue_frame(w, h, $urandom_range(0, 3) == 0 ? 1 : 0, $urandom_range(0, 1));
      sent += w * h + 3 * w + 10;
      settle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pixels_due.size() == 0) begin
      $display("bayer_mhc_demosaic regression: pass");
    end else begin
      $display("bayer_mhc_demosaic regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bmd_pkg.sv
design/bmd_colmem.sv
design/bmd_kernel.sv
design/bayer_mhc_demosaic.sv
tb/sv/tb_bayer_mhc_demosaic.sv
